>>> src/rlos_pkg.sv
// Shared types and constants for the one-wire RGB LED serializer.
// Used by the register block, the pixel queue, the symbol engine and the top level.
`default_nettype none
package rlos_pkg;

  localparam int unsigned PIXEL_BITS  = 24;
  localparam int unsigned LEFT_W      = 5;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned DATA_W      = 32;

  // register indexes
  localparam logic [2:0] REG_ZERO_HIGH = 3'd0;
  localparam logic [2:0] REG_ZERO_LOW  = 3'd1;
  localparam logic [2:0] REG_ONE_HIGH  = 3'd2;
  localparam logic [2:0] REG_ONE_LOW   = 3'd3;
  localparam logic [2:0] REG_LATCH_LOW = 3'd4;

  localparam logic [7:0]  ZERO_HIGH_RST = 8'd6;
  localparam logic [7:0]  ZERO_LOW_RST  = 8'd18;
  localparam logic [7:0]  ONE_HIGH_RST  = 8'd14;
  localparam logic [7:0]  ONE_LOW_RST   = 8'd12;
  localparam logic [15:0] LATCH_LOW_RST = 16'd2000;

  // timing as seen by the symbol engine, zero already forced to one
  typedef struct packed {
    logic [7:0]  zero_high;
    logic [7:0]  zero_low;
    logic [7:0]  one_high;
    logic [7:0]  one_low;
    logic [15:0] latch_low;
  } timing_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] bits;
    logic                  eof;
  } pixel_t;

  function automatic logic [7:0] min_one8(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic logic [15:0] min_one16(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage
`default_nettype wire

>>> src/rgb_led_one_wire_serializer_unit.sv
// One-wire RGB LED pulse encoder, top level: registers, pixel queue, symbol engine.
// A pixel request is written to the queue, popped into the engine's shift register, then
// registered as its first symbol. Throughput: one symbol per cycle the consumer takes; the
// next pixel is popped only once the last symbol is sent. The pulse consumer normally sets the pace.
// Reset: asynchronous, clears queue and engine, loads the timing registers' defaults.
// Depends on rlos_pkg, rlos_cfg, rlos_front and rlos_back.
`default_nettype none
module rgb_led_one_wire_serializer_unit #(
  parameter int unsigned QueueDepth = rlos_pkg::QUEUE_DEPTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rlos_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [rlos_pkg::DATA_W-1:0]  pwdata,
  output logic      [rlos_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [7:0]                   green_i,
  input  wire logic [7:0]                   red_i,
  input  wire logic [7:0]                   blue_i,
  input  wire logic                         end_of_frame_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [7:0]                        high_time_o,
  output logic [15:0]                       low_time_o,
  output logic                              bit_sent_o,
  output logic                              is_latch_o,
  output logic                              last_symbol_o
);

  rlos_pkg::timing_t timing;
  rlos_pkg::pixel_t  q_pixel;
  logic              q_valid, q_pop;

  rlos_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .timing_o (timing)
  );

  rlos_front #(.Depth(QueueDepth)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .green_i        (green_i),
    .red_i          (red_i),
    .blue_i         (blue_i),
    .end_of_frame_i (end_of_frame_i),
    .q_valid_o      (q_valid),
    .q_pop_i        (q_pop),
    .q_pixel_o      (q_pixel)
  );

  rlos_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .timing_i      (timing),
    .q_valid_i     (q_valid),
    .q_pop_o       (q_pop),
    .q_pixel_i     (q_pixel),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .high_time_o   (high_time_o),
    .low_time_o    (low_time_o),
    .bit_sent_o    (bit_sent_o),
    .is_latch_o    (is_latch_o),
    .last_symbol_o (last_symbol_o)
  );

`ifndef NO_ASSERTIONS
  // the latch symbol carries no high part and always closes the pixel
  a_latch_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_latch_o |-> high_time_o == 8'd0 && !bit_sent_o && last_symbol_o)
    else $error("latch symbol malformed");

  // data symbols never have an empty high part
  a_data_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_latch_o |-> high_time_o != 8'd0)
    else $error("data symbol with zero high time");

  // no symbol has an empty low part
  a_low_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> low_time_o != 16'd0)
    else $error("symbol with zero low time");

  // a data symbol flagged last leaves no latch behind it
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_symbol_o |=> !(out_valid_o && is_latch_o))
    else $error("latch after last symbol");
`endif

endmodule
`default_nettype wire

>>> src/rlos_cfg.sv
// APB-style timing registers for the LED serializer.
// Depends on rlos_pkg for register indexes, reset values and timing_t.
`default_nettype none
module rlos_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rlos_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [rlos_pkg::DATA_W-1:0]  pwdata,
  output logic      [rlos_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output rlos_pkg::timing_t                 timing_o
);

  logic [7:0]  zero_high_q, zero_low_q, one_high_q, one_low_q;
  logic [15:0] latch_low_q;
  logic [2:0]  idx;
  logic        wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_high_q <= rlos_pkg::ZERO_HIGH_RST;
      zero_low_q  <= rlos_pkg::ZERO_LOW_RST;
      one_high_q  <= rlos_pkg::ONE_HIGH_RST;
      one_low_q   <= rlos_pkg::ONE_LOW_RST;
      latch_low_q <= rlos_pkg::LATCH_LOW_RST;
    end else if (wr_en) begin
      case (idx)
        rlos_pkg::REG_ZERO_HIGH: zero_high_q <= pwdata[7:0];
        rlos_pkg::REG_ZERO_LOW:  zero_low_q  <= pwdata[7:0];
        rlos_pkg::REG_ONE_HIGH:  one_high_q  <= pwdata[7:0];
        rlos_pkg::REG_ONE_LOW:   one_low_q   <= pwdata[7:0];
        rlos_pkg::REG_LATCH_LOW: latch_low_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rlos_pkg::REG_ZERO_HIGH: prdata = {24'd0, zero_high_q};
      rlos_pkg::REG_ZERO_LOW:  prdata = {24'd0, zero_low_q};
      rlos_pkg::REG_ONE_HIGH:  prdata = {24'd0, one_high_q};
      rlos_pkg::REG_ONE_LOW:   prdata = {24'd0, one_low_q};
      rlos_pkg::REG_LATCH_LOW: prdata = {16'd0, latch_low_q};
      default:                 prdata = '0;
    endcase
  end

  always_comb begin
    timing_o.zero_high = rlos_pkg::min_one8(zero_high_q);
    timing_o.zero_low  = rlos_pkg::min_one8(zero_low_q);
    timing_o.one_high  = rlos_pkg::min_one8(one_high_q);
    timing_o.one_low   = rlos_pkg::min_one8(one_low_q);
    timing_o.latch_low = rlos_pkg::min_one16(latch_low_q);
  end

endmodule
`default_nettype wire

>>> src/rlos_front.sv
// Front end: takes pixel requests, packs them and holds them in a small queue.
// Depends on rlos_pkg for pixel_t.
`default_nettype none
module rlos_front #(
  parameter int unsigned Depth = rlos_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        green_i,
  input  wire logic [7:0]        red_i,
  input  wire logic [7:0]        blue_i,
  input  wire logic              end_of_frame_i,
  output logic                   q_valid_o,
  input  wire logic              q_pop_i,
  output rlos_pkg::pixel_t       q_pixel_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  rlos_pkg::pixel_t    mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                push, pop;

  assign in_ready_o = (cnt_q != CntFull);
  assign q_valid_o  = (cnt_q != '0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_pixel_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{bits: {green_i, red_i, blue_i}, eof: end_of_frame_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> src/rlos_back.sv
// Back end: shifts a queued pixel out as pulse symbols through an output register.
// Depends on rlos_pkg for pixel_t, timing_t and the pixel width.
`default_nettype none
module rlos_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rlos_pkg::timing_t timing_i,
  input  wire logic              q_valid_i,
  output logic                   q_pop_o,
  input  wire rlos_pkg::pixel_t  q_pixel_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             high_time_o,
  output logic [15:0]            low_time_o,
  output logic                   bit_sent_o,
  output logic                   is_latch_o,
  output logic                   last_symbol_o
);

  localparam logic [rlos_pkg::LEFT_W-1:0] AllBits = rlos_pkg::LEFT_W'(rlos_pkg::PIXEL_BITS);
  localparam logic [rlos_pkg::LEFT_W-1:0] OneLeft = rlos_pkg::LEFT_W'(1);

  logic                              busy_q, latch_q, out_valid_q;
  logic [rlos_pkg::PIXEL_BITS-1:0]   shift_q;
  logic [rlos_pkg::LEFT_W-1:0]       left_q;
  logic                              advance, emit, data_sym, cur_bit;

  assign advance  = !out_valid_q || out_ready_i;
  assign emit     = busy_q && advance;
  assign data_sym = (left_q != '0);
  assign cur_bit  = shift_q[rlos_pkg::PIXEL_BITS-1];
  assign q_pop_o  = !busy_q && q_valid_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      latch_q     <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) out_valid_q <= busy_q;
      if (q_pop_o) begin
        busy_q  <= 1'b1;
        left_q  <= AllBits;
        latch_q <= q_pixel_i.eof;
      end else if (emit) begin
        if (data_sym) begin
          left_q <= left_q - 1'b1;
          if (left_q == OneLeft && !latch_q) busy_q <= 1'b0;
        end else begin
          latch_q <= 1'b0;
          busy_q  <= 1'b0;
        end
      end
    end
  end

  // payload: shift register and output fields
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      shift_q <= q_pixel_i.bits;
    end else if (emit && data_sym) begin
      shift_q <= {shift_q[rlos_pkg::PIXEL_BITS-2:0], 1'b0};
    end
    if (emit) begin
      if (data_sym) begin
        high_time_o   <= cur_bit ? timing_i.one_high : timing_i.zero_high;
        low_time_o    <= {8'd0, cur_bit ? timing_i.one_low : timing_i.zero_low};
        bit_sent_o    <= cur_bit;
        is_latch_o    <= 1'b0;
        last_symbol_o <= (left_q == OneLeft) && !latch_q;
      end else begin
        high_time_o   <= 8'd0;
        low_time_o    <= timing_i.latch_low;
        bit_sent_o    <= 1'b0;
        is_latch_o    <= 1'b1;
        last_symbol_o <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
